// ----- rtl/core/msre_pkg.sv -----
// shared codes for the special/regimm execute unit
// instruction function codes, regimm codes, status and command codes
// no dependencies
`default_nettype none
package msre_pkg;
	localparam logic [1:0] CMD_SPECIAL = 2'd0;
	localparam logic [1:0] CMD_REGIMM  = 2'd1;
	localparam logic [1:0] CMD_LOAD    = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_TRAP    = 3'd1;
	localparam logic [2:0] ST_BREAK   = 3'd2;
	localparam logic [2:0] ST_DIVZERO = 3'd3;
	localparam logic [2:0] ST_INVALID = 3'd4;
	localparam logic [2:0] ST_SYSCALL = 3'd5;

	localparam logic [5:0] F_SLL     = 6'h00;
	localparam logic [5:0] F_SRL     = 6'h02;
	localparam logic [5:0] F_SRA     = 6'h03;
	localparam logic [5:0] F_SLLV    = 6'h04;
	localparam logic [5:0] F_SRLV    = 6'h06;
	localparam logic [5:0] F_SRAV    = 6'h07;
	localparam logic [5:0] F_JR      = 6'h08;
	localparam logic [5:0] F_JALR    = 6'h09;
	localparam logic [5:0] F_MOVZ    = 6'h0A;
	localparam logic [5:0] F_MOVN    = 6'h0B;
	localparam logic [5:0] F_SYSCALL = 6'h0C;
	localparam logic [5:0] F_BREAK   = 6'h0D;
	localparam logic [5:0] F_SYNC    = 6'h0F;
	localparam logic [5:0] F_MFHI    = 6'h10;
	localparam logic [5:0] F_MTHI    = 6'h11;
	localparam logic [5:0] F_MFLO    = 6'h12;
	localparam logic [5:0] F_MTLO    = 6'h13;
	localparam logic [5:0] F_DSLLV   = 6'h14;
	localparam logic [5:0] F_DSRLV   = 6'h16;
	localparam logic [5:0] F_DSRAV   = 6'h17;
	localparam logic [5:0] F_MULT    = 6'h18;
	localparam logic [5:0] F_MULTU   = 6'h19;
	localparam logic [5:0] F_DIV     = 6'h1A;
	localparam logic [5:0] F_DIVU    = 6'h1B;
	localparam logic [5:0] F_DMULT   = 6'h1C;
	localparam logic [5:0] F_DMULTU  = 6'h1D;
	localparam logic [5:0] F_DDIV    = 6'h1E;
	localparam logic [5:0] F_DDIVU   = 6'h1F;
	localparam logic [5:0] F_ADD     = 6'h20;
	localparam logic [5:0] F_ADDU    = 6'h21;
	localparam logic [5:0] F_SUB     = 6'h22;
	localparam logic [5:0] F_SUBU    = 6'h23;
	localparam logic [5:0] F_AND     = 6'h24;
	localparam logic [5:0] F_OR      = 6'h25;
	localparam logic [5:0] F_XOR     = 6'h26;
	localparam logic [5:0] F_NOR     = 6'h27;
	localparam logic [5:0] F_SLT     = 6'h2A;
	localparam logic [5:0] F_SLTU    = 6'h2B;
	localparam logic [5:0] F_DADD    = 6'h2C;
	localparam logic [5:0] F_DADDU   = 6'h2D;
	localparam logic [5:0] F_DSUB    = 6'h2E;
	localparam logic [5:0] F_DSUBU   = 6'h2F;
	localparam logic [5:0] F_TGE     = 6'h30;
	localparam logic [5:0] F_TGEU    = 6'h31;
	localparam logic [5:0] F_TLT     = 6'h32;
	localparam logic [5:0] F_TLTU    = 6'h33;
	localparam logic [5:0] F_TEQ     = 6'h34;
	localparam logic [5:0] F_TNE     = 6'h36;
	localparam logic [5:0] F_DSLL    = 6'h38;
	localparam logic [5:0] F_DSRL    = 6'h3A;
	localparam logic [5:0] F_DSRA    = 6'h3B;
	localparam logic [5:0] F_DSLL32  = 6'h3C;
	localparam logic [5:0] F_DSRL32  = 6'h3E;
	localparam logic [5:0] F_DSRA32  = 6'h3F;

	localparam logic [4:0] RI_BLTZ    = 5'h00;
	localparam logic [4:0] RI_BGEZ    = 5'h01;
	localparam logic [4:0] RI_BLTZL   = 5'h02;
	localparam logic [4:0] RI_BGEZL   = 5'h03;
	localparam logic [4:0] RI_TGEI    = 5'h08;
	localparam logic [4:0] RI_TGEIU   = 5'h09;
	localparam logic [4:0] RI_TLTI    = 5'h0A;
	localparam logic [4:0] RI_TLTIU   = 5'h0B;
	localparam logic [4:0] RI_TEQI    = 5'h0C;
	localparam logic [4:0] RI_TNEI    = 5'h0E;
	localparam logic [4:0] RI_BLTZAL  = 5'h10;
	localparam logic [4:0] RI_BGEZAL  = 5'h11;
	localparam logic [4:0] RI_BLTZALL = 5'h12;
	localparam logic [4:0] RI_BGEZALL = 5'h13;

	localparam logic [4:0] LINK_REG = 5'd31;

	function automatic logic [63:0] sx32(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/msre_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module msre_ram #(
	parameter int Width = 64,
	parameter int Depth = 32
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire  [$clog2(Depth)-1:0]  waddr,
	input  wire  [Width-1:0]          wdata,
	input  wire                       re,
	input  wire  [$clog2(Depth)-1:0]  raddr,
	output logic [Width-1:0]          rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/mips64_special_regimm_execute.sv -----
// mips64 special/regimm execute unit: register file in two ram copies, hi/lo, serial mul/div
// depends on msre_pkg and msre_ram
// most instructions: beat registered on accept, result registered in S_EXEC once output free
// mul/div: S_MD runs the one-bit-per-cycle shift-add / restoring unit, then S_FIX
// one instruction at a time: next beat taken only once back in S_IDLE
// reset: valid bits, hi, lo, state and outputs cleared; unwritten registers read as zero
`default_nettype none
module mips64_special_regimm_execute (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [1:0]   s_tuser,   // command
	input  wire  [167:0] s_tdata,   // instr, pc, load_index, load_value, pad
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [335:0] m_tdata    // status, next_pc, branch_pending, branch_target,
	                                // write_enable, write_index, write_value, hi_value,
	                                // lo_value, pad
);
	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MD, S_FIX} state_t;

	state_t       state_q;
	logic [1:0]   cmd_s1;
	logic [31:0]  ins_s1;
	logic [63:0]  pc_s1;
	logic [4:0]   lidx_s1;
	logic [63:0]  lval_s1;
	logic [31:0]  vld_q;
	logic [63:0]  hi_q, lo_q;
	logic [63:0]  rd_a, rd_b;

	logic         md_div_q, md_w32_q, md_nq_q, md_nr_q;
	logic [63:0]  md_acc_q, md_lo_q, md_op_q, md_corr_q;
	logic [5:0]   md_cnt_q;

	logic         o_valid_q;
	logic [2:0]   o_st_q;
	logic [63:0]  o_next_q, o_bt_q, o_wv_q, o_hi_q, o_lo_q;
	logic         o_bp_q, o_we_q;
	logic [4:0]   o_wi_q;

	logic         accept, out_free, exec_fire, o_load;
	logic [63:0]  a, b, imm;
	logic [31:0]  a32, b32;
	logic [4:0]   rs, rt, sh;
	logic [5:0]   fn;

	logic [2:0]   st;
	logic [63:0]  nxt, bt, wv, nhi, nlo;
	logic         bp, w, halt, trap, md_go;
	logic [4:0]   wi;
	logic         g_div, g_w32, g_nq, g_nr;
	logic [63:0]  g_mc, g_ml, g_corr;

	logic [64:0]  mul_sum, div_sh, div_diff;
	logic [63:0]  fq, fr, fhi, flo;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !o_valid_q || m_tready;
	assign exec_fire = (state_q == S_EXEC) && out_free;
	assign o_load   = (exec_fire && !md_go) || ((state_q == S_FIX) && out_free);

	assign rs = ins_s1[25:21];
	assign rt = ins_s1[20:16];
	assign sh = ins_s1[10:6];
	assign fn = ins_s1[5:0];
	assign a  = vld_q[rs] ? rd_a : 64'd0;
	assign b  = vld_q[rt] ? rd_b : 64'd0;
	assign a32 = a[31:0];
	assign b32 = b[31:0];
	assign imm = {{48{ins_s1[15]}}, ins_s1[15:0]};

	msre_ram #(.Width(64), .Depth(32)) u_ram_a (
		.clk(clk), .we(exec_fire && w), .waddr(wi), .wdata(wv),
		.re(accept), .raddr(s_tdata[25:21]), .rdata(rd_a)
	);

	msre_ram #(.Width(64), .Depth(32)) u_ram_b (
		.clk(clk), .we(exec_fire && w), .waddr(wi), .wdata(wv),
		.re(accept), .raddr(s_tdata[20:16]), .rdata(rd_b)
	);

	always_comb begin
		logic [31:0] s32;
		logic [63:0] s64;
		logic        ge;
		s32 = '0;
		s64 = '0;
		ge = !a[63];
		st = msre_pkg::ST_OK;
		nxt = pc_s1 + 64'd4;
		bp = 1'b0;
		bt = '0;
		w = 1'b0;
		wi = '0;
		wv = '0;
		nhi = hi_q;
		nlo = lo_q;
		halt = 1'b0;
		trap = 1'b0;
		md_go = 1'b0;
		g_div = 1'b0;
		g_w32 = 1'b0;
		g_nq = 1'b0;
		g_nr = 1'b0;
		g_mc = a;
		g_ml = b;
		g_corr = '0;
		if (cmd_s1 == msre_pkg::CMD_LOAD) begin
			wi = lidx_s1;
			wv = lval_s1;
			w = 1'b1;
			nxt = pc_s1;
		end else if (cmd_s1 == msre_pkg::CMD_SPECIAL) begin
			wi = ins_s1[15:11];
			unique case (fn)
				msre_pkg::F_ADD: begin
					s32 = a32 + b32;
					if (((a32 ^ s32) & (b32 ^ s32) & 32'h8000_0000) != 32'd0) begin
						st = msre_pkg::ST_TRAP;
						halt = 1'b1;
					end else begin
						wv = msre_pkg::sx32(s32);
						w = 1'b1;
					end
				end
				msre_pkg::F_ADDU: begin
					wv = msre_pkg::sx32(a32 + b32);
					w = 1'b1;
				end
				msre_pkg::F_SUB: begin
					s32 = a32 - b32;
					if (((a32 ^ b32) & (a32 ^ s32) & 32'h8000_0000) != 32'd0) begin
						st = msre_pkg::ST_TRAP;
						halt = 1'b1;
					end else begin
						wv = msre_pkg::sx32(s32);
						w = 1'b1;
					end
				end
				msre_pkg::F_SUBU: begin
					wv = msre_pkg::sx32(a32 - b32);
					w = 1'b1;
				end
				msre_pkg::F_DADD: begin
					s64 = a + b;
					wv = s64;
					if ((a[63] == b[63]) && (s64[63] != a[63])) begin
						st = msre_pkg::ST_TRAP;
						halt = 1'b1;
					end else begin
						w = 1'b1;
					end
				end
				msre_pkg::F_DADDU: begin
					wv = a + b;
					w = 1'b1;
				end
				msre_pkg::F_DSUB: begin
					s64 = a - b;
					wv = s64;
					if ((a[63] != b[63]) && (s64[63] != a[63])) begin
						st = msre_pkg::ST_TRAP;
						halt = 1'b1;
					end else begin
						w = 1'b1;
					end
				end
				msre_pkg::F_DSUBU: begin
					wv = a - b;
					w = 1'b1;
				end
				msre_pkg::F_AND: begin wv = a & b; w = 1'b1; end
				msre_pkg::F_OR:  begin wv = a | b; w = 1'b1; end
				msre_pkg::F_XOR: begin wv = a ^ b; w = 1'b1; end
				msre_pkg::F_NOR: begin wv = ~(a | b); w = 1'b1; end
				msre_pkg::F_SLT: begin
					wv = {63'd0, $signed(a) < $signed(b)};
					w = 1'b1;
				end
				msre_pkg::F_SLTU: begin
					wv = {63'd0, a < b};
					w = 1'b1;
				end
				msre_pkg::F_SLL: begin wv = msre_pkg::sx32(b32 << sh); w = 1'b1; end
				msre_pkg::F_SRL: begin wv = msre_pkg::sx32(b32 >> sh); w = 1'b1; end
				msre_pkg::F_SRA: begin
					wv = msre_pkg::sx32(32'($signed(b32) >>> sh));
					w = 1'b1;
				end
				msre_pkg::F_SLLV: begin
					wv = msre_pkg::sx32(b32 << a32[4:0]);
					w = 1'b1;
				end
				msre_pkg::F_SRLV: begin
					wv = msre_pkg::sx32(b32 >> a32[4:0]);
					w = 1'b1;
				end
				msre_pkg::F_SRAV: begin
					wv = msre_pkg::sx32(32'($signed(b32) >>> a32[4:0]));
					w = 1'b1;
				end
				msre_pkg::F_DSLL: begin wv = b << sh; w = 1'b1; end
				msre_pkg::F_DSRL: begin wv = b >> sh; w = 1'b1; end
				msre_pkg::F_DSRA: begin wv = 64'($signed(b) >>> sh); w = 1'b1; end
				msre_pkg::F_DSLL32: begin wv = b << {1'b1, sh}; w = 1'b1; end
				msre_pkg::F_DSRL32: begin wv = b >> {1'b1, sh}; w = 1'b1; end
				msre_pkg::F_DSRA32: begin
					wv = 64'($signed(b) >>> {1'b1, sh});
					w = 1'b1;
				end
				msre_pkg::F_DSLLV: begin wv = b << a[5:0]; w = 1'b1; end
				msre_pkg::F_DSRLV: begin wv = b >> a[5:0]; w = 1'b1; end
				msre_pkg::F_DSRAV: begin
					wv = 64'($signed(b) >>> a[5:0]);
					w = 1'b1;
				end
				msre_pkg::F_JR: begin
					bp = 1'b1;
					bt = a;
				end
				msre_pkg::F_JALR: begin
					bp = 1'b1;
					bt = a;
					wv = pc_s1 + 64'd8;
					w = 1'b1;
				end
				msre_pkg::F_MOVZ: begin
					wv = a;
					w = (b == 64'd0);
				end
				msre_pkg::F_MOVN: begin
					wv = a;
					w = (b != 64'd0);
				end
				msre_pkg::F_MFHI: begin wv = hi_q; w = 1'b1; end
				msre_pkg::F_MFLO: begin wv = lo_q; w = 1'b1; end
				msre_pkg::F_MTHI: nhi = a;
				msre_pkg::F_MTLO: nlo = a;
				msre_pkg::F_MULT: begin
					md_go = 1'b1;
					g_w32 = 1'b1;
					g_mc = msre_pkg::sx32(a32);
					g_ml = msre_pkg::sx32(b32);
				end
				msre_pkg::F_MULTU: begin
					md_go = 1'b1;
					g_w32 = 1'b1;
					g_mc = {32'd0, a32};
					g_ml = {32'd0, b32};
				end
				msre_pkg::F_DMULT: begin
					md_go = 1'b1;
					g_corr = (a[63] ? b : 64'd0) + (b[63] ? a : 64'd0);
				end
				msre_pkg::F_DMULTU: md_go = 1'b1;
				msre_pkg::F_DIV: begin
					if (b32 == 32'd0) begin
						st = msre_pkg::ST_DIVZERO;
						halt = 1'b1;
					end else begin
						md_go = 1'b1;
						g_div = 1'b1;
						g_w32 = 1'b1;
						g_nq = a32[31] ^ b32[31];
						g_nr = a32[31];
						g_ml = {32'd0, a32[31] ? 32'd0 - a32 : a32};
						g_mc = {32'd0, b32[31] ? 32'd0 - b32 : b32};
					end
				end
				msre_pkg::F_DIVU: begin
					if (b32 == 32'd0) begin
						st = msre_pkg::ST_DIVZERO;
						halt = 1'b1;
					end else begin
						md_go = 1'b1;
						g_div = 1'b1;
						g_w32 = 1'b1;
						g_ml = {32'd0, a32};
						g_mc = {32'd0, b32};
					end
				end
				msre_pkg::F_DDIV: begin
					if (b == 64'd0) begin
						st = msre_pkg::ST_DIVZERO;
						halt = 1'b1;
					end else begin
						md_go = 1'b1;
						g_div = 1'b1;
						g_nq = a[63] ^ b[63];
						g_nr = a[63];
						g_ml = a[63] ? 64'd0 - a : a;
						g_mc = b[63] ? 64'd0 - b : b;
					end
				end
				msre_pkg::F_DDIVU: begin
					if (b == 64'd0) begin
						st = msre_pkg::ST_DIVZERO;
						halt = 1'b1;
					end else begin
						md_go = 1'b1;
						g_div = 1'b1;
						g_ml = a;
						g_mc = b;
					end
				end
				msre_pkg::F_BREAK: begin
					st = msre_pkg::ST_BREAK;
					halt = 1'b1;
				end
				msre_pkg::F_SYSCALL: st = msre_pkg::ST_SYSCALL;
				msre_pkg::F_SYNC: ;
				msre_pkg::F_TEQ:  trap = (a == b);
				msre_pkg::F_TNE:  trap = (a != b);
				msre_pkg::F_TGE:  trap = !($signed(a) < $signed(b));
				msre_pkg::F_TGEU: trap = (a >= b);
				msre_pkg::F_TLT:  trap = ($signed(a) < $signed(b));
				msre_pkg::F_TLTU: trap = (a < b);
				default: begin
					st = msre_pkg::ST_INVALID;
					halt = 1'b1;
				end
			endcase
		end else if (cmd_s1 == msre_pkg::CMD_REGIMM) begin
			unique case (rt) inside
				msre_pkg::RI_BLTZ, msre_pkg::RI_BGEZ, msre_pkg::RI_BLTZL,
				msre_pkg::RI_BGEZL, msre_pkg::RI_BLTZAL, msre_pkg::RI_BGEZAL,
				msre_pkg::RI_BLTZALL, msre_pkg::RI_BGEZALL: begin
					if (rt[4]) begin
						wi = msre_pkg::LINK_REG;
						wv = pc_s1 + 64'd8;
						w = 1'b1;
					end
					if (rt[0] ? ge : !ge) begin
						bp = 1'b1;
						bt = pc_s1 + 64'd4 + {imm[61:0], 2'b00};
					end else if (rt[1]) begin
						nxt = pc_s1 + 64'd8;
					end
				end
				msre_pkg::RI_TEQI:  trap = (a == imm);
				msre_pkg::RI_TNEI:  trap = (a != imm);
				msre_pkg::RI_TGEI:  trap = !($signed(a) < $signed(imm));
				msre_pkg::RI_TGEIU: trap = (a >= imm);
				msre_pkg::RI_TLTI:  trap = ($signed(a) < $signed(imm));
				msre_pkg::RI_TLTIU: trap = (a < imm);
				default: begin
					st = msre_pkg::ST_INVALID;
					halt = 1'b1;
				end
			endcase
		end else begin
			st = msre_pkg::ST_INVALID;
			halt = 1'b1;
		end
		if (trap) begin
			st = msre_pkg::ST_TRAP;
			halt = 1'b1;
		end
		if (halt) begin
			nxt = pc_s1;
			bp = 1'b0;
			bt = '0;
			w = 1'b0;
			nhi = hi_q;
			nlo = lo_q;
		end
		if (w && wi == 5'd0) begin
			w = 1'b0;
		end
		if (!w) begin
			wi = '0;
			wv = '0;
		end
	end

	// one step of shift-add multiply or restoring divide
	assign mul_sum  = {1'b0, md_acc_q} + (md_lo_q[0] ? {1'b0, md_op_q} : 65'd0);
	assign div_sh   = {md_acc_q, md_lo_q[63]};
	assign div_diff = div_sh - {1'b0, md_op_q};

	always_comb begin
		fq = md_nq_q ? 64'd0 - md_lo_q : md_lo_q;
		fr = md_nr_q ? 64'd0 - md_acc_q : md_acc_q;
		if (md_div_q) begin
			flo = md_w32_q ? msre_pkg::sx32(fq[31:0]) : fq;
			fhi = md_w32_q ? msre_pkg::sx32(fr[31:0]) : fr;
		end else begin
			flo = md_w32_q ? msre_pkg::sx32(md_lo_q[31:0]) : md_lo_q;
			fhi = md_w32_q ? msre_pkg::sx32(md_lo_q[63:32]) : md_acc_q - md_corr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= s_tuser;
			ins_s1  <= s_tdata[31:0];
			pc_s1   <= s_tdata[95:32];
			lidx_s1 <= s_tdata[100:96];
			lval_s1 <= s_tdata[164:101];
		end
		if (exec_fire && md_go) begin
			md_div_q  <= g_div;
			md_w32_q  <= g_w32;
			md_nq_q   <= g_nq;
			md_nr_q   <= g_nr;
			md_acc_q  <= '0;
			md_lo_q   <= g_ml;
			md_op_q   <= g_mc;
			md_corr_q <= g_corr;
		end else if (state_q == S_MD) begin
			if (md_div_q) begin
				md_acc_q <= div_diff[64] ? div_sh[63:0] : div_diff[63:0];
				md_lo_q  <= {md_lo_q[62:0], !div_diff[64]};
			end else begin
				md_acc_q <= mul_sum[64:1];
				md_lo_q  <= {mul_sum[0], md_lo_q[63:1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			vld_q     <= '0;
			hi_q      <= '0;
			lo_q      <= '0;
			md_cnt_q  <= '0;
			o_valid_q <= 1'b0;
			o_st_q    <= '0;
			o_next_q  <= '0;
			o_bp_q    <= 1'b0;
			o_bt_q    <= '0;
			o_we_q    <= 1'b0;
			o_wi_q    <= '0;
			o_wv_q    <= '0;
			o_hi_q    <= '0;
			o_lo_q    <= '0;
		end else begin
			if (o_load) begin
				o_valid_q <= 1'b1;
			end else if (m_tready) begin
				o_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						if (w) begin
							vld_q[wi] <= 1'b1;
						end
						if (md_go) begin
							md_cnt_q <= '0;
							state_q  <= S_MD;
						end else begin
							hi_q      <= nhi;
							lo_q      <= nlo;
							o_st_q    <= st;
							o_next_q  <= nxt;
							o_bp_q    <= bp;
							o_bt_q    <= bt;
							o_we_q    <= w;
							o_wi_q    <= wi;
							o_wv_q    <= wv;
							o_hi_q    <= nhi;
							o_lo_q    <= nlo;
							state_q   <= S_IDLE;
						end
					end
				end
				S_MD: begin
					md_cnt_q <= md_cnt_q + 6'd1;
					if (md_cnt_q == 6'd63) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					if (out_free) begin
						hi_q      <= fhi;
						lo_q      <= flo;
						o_st_q    <= msre_pkg::ST_OK;
						o_next_q  <= pc_s1 + 64'd4;
						o_bp_q    <= 1'b0;
						o_bt_q    <= '0;
						o_we_q    <= 1'b0;
						o_wi_q    <= '0;
						o_wv_q    <= '0;
						o_hi_q    <= fhi;
						o_lo_q    <= flo;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {6'd0, o_lo_q, o_hi_q, o_wv_q, o_wi_q, o_we_q, o_bt_q, o_bp_q,
		o_next_q, o_st_q};

`ifndef SYNTHESIS
	a_no_zero_write: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && w) |-> (wi != 5'd0))
		else $error("write aimed at register zero");
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted beat not executed");
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && (o_st_q == msre_pkg::ST_TRAP || o_st_q == msre_pkg::ST_BREAK
			|| o_st_q == msre_pkg::ST_DIVZERO || o_st_q == msre_pkg::ST_INVALID))
		|-> (!o_we_q && !o_bp_q))
		else $error("halting result carries a write or branch");
`endif
endmodule
`default_nettype wire
